// File: rtl/core/mbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbm_pkg: shared types and codes of the memory bank mapper
// Machine modes, bus operation codes, control bit positions, page numbers
// and the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package mbm_pkg;

	// machine modes
	localparam logic [2:0] MODE_48K      = 3'd0;
	localparam logic [2:0] MODE_48K_IF1  = 3'd1;
	localparam logic [2:0] MODE_48K_DISK = 3'd2;
	localparam logic [2:0] MODE_SHADOW   = 3'd3;
	localparam logic [2:0] MODE_128K     = 3'd4;
	localparam logic [2:0] MODE_128K_IF1 = 3'd5;
	localparam logic [2:0] MODE_128K_DSK = 3'd6;
	localparam logic [2:0] MODE_UNUSED   = 3'd7;

	// bus operations
	localparam logic [2:0] OP_PAGE_WR    = 3'd0;
	localparam logic [2:0] OP_BIT_WR     = 3'd1;
	localparam logic [2:0] OP_TRAP_ENTER = 3'd2;
	localparam logic [2:0] OP_TRAP_EXIT  = 3'd3;
	localparam logic [2:0] OP_FREEZE_ON  = 3'd4;
	localparam logic [2:0] OP_FREEZE_OFF = 3'd5;
	localparam logic [2:0] OP_SPEECH_TGL = 3'd6;
	localparam logic [2:0] OP_SPEECH_OFF = 3'd7;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_PRES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_PRES  = 2'd2;

	// control byte bit positions
	localparam int unsigned BIT_RAM_HI  = 5;
	localparam int unsigned BIT_ROM_SEL = 4;
	localparam int unsigned BIT_VIDEO   = 3;
	localparam int unsigned BIT_LOCK_SH = 2;
	localparam int unsigned BIT_ROM_LO  = 1;

	// pages
	localparam logic [3:0] PAGE_ROM0   = 4'd0;
	localparam logic [3:0] PAGE_DISK   = 4'd1;
	localparam logic [3:0] PAGE_ROM2   = 4'd2;
	localparam logic [3:0] PAGE_ROM3   = 4'd3;
	localparam logic [3:0] PAGE_RAM4   = 4'd4;
	localparam logic [3:0] PAGE_RAM5   = 4'd5;
	localparam logic [3:0] PAGE_RAM6   = 4'd6;
	localparam logic [3:0] PAGE_RAM7   = 4'd7;
	localparam logic [3:0] PAGE_RAM8   = 4'd8;
	localparam logic [3:0] PAGE_FREEZE = 4'd11;
	localparam logic [3:0] PAGE_SPEECH = 4'd12;
	localparam logic [3:0] PAGE_BANK0  = 4'd3;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0] window0_page;
		logic [3:0] window1_page;
		logic [3:0] window2_page;
		logic [3:0] window3_page;
		logic       shadow_video;
		logic [7:0] control_byte;
	} out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/mbm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbm_if: valid/ready channels of the memory bank mapper
// One interface for bus events in, one for mapping results out.
// ----------------------------------------------------------------------------
interface mbm_in_if
	import mbm_pkg::*;
	();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface mbm_out_if
	import mbm_pkg::*;
	();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: rtl/core/memory_bank_mapper_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// memory_bank_mapper_top: 64K address space page mapper
// Keeps the paging control byte and the overlay ROM flags, applies one bus
// event per transaction and reports the page behind each 16K window.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                               handshake
//  in_ch     sink       operation, data_byte                  valid/ready
//  out_ch    source     window0..3_page, shadow_video,        valid/ready
//                       control_byte
//  cfg       write      cfg_index, cfg_data                   cfg_we
//
// One transaction per cycle while in_ch is not stalled: the state update and
// the window map sit between the mapper state registers and a two-entry
// result buffer, and each result is registered into that buffer.
// The result buffer (head plus skid entry) lets in_ch keep accepting while
// one result waits; in_ch stalls only once both entries are full.
// arst_n clears the control byte, overlay flags, configuration and buffer.
// ----------------------------------------------------------------------------
module memory_bank_mapper_top
	import mbm_pkg::*;
	(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mbm_in_if.sink                     in_ch,
	mbm_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [2:0] mode_q;
	logic       frz_pres_q;
	logic       spc_pres_q;

	// mapper state
	logic [7:0] ctrl_q;
	logic       disk_act_q;
	logic       frz_act_q;
	logic       spc_act_q;

	// result buffer
	logic      head_valid_q;
	logic      skid_valid_q;
	out_item_t head_q;
	out_item_t skid_q;

	logic [2:0] mode_eff;
	logic       is_128k;
	logic       in_fire;
	logic       out_fire;
	logic [7:0] ctrl_n;
	logic       disk_n;
	logic       frz_n;
	logic       spc_n;
	out_item_t  res;

	// mode 7 is unused and behaves as plain 48K
	assign mode_eff = (mode_q == MODE_UNUSED) ? MODE_48K : mode_q;
	assign is_128k  = mode_eff[2];

	assign in_ch.ready = !skid_valid_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_ch.valid && out_ch.ready;

	// ---- event decode: next mapper state ----
	always_comb begin
		ctrl_n = ctrl_q;
		disk_n = disk_act_q;
		frz_n  = frz_act_q;
		spc_n  = spc_act_q;
		unique case (in_ch.item.operation)
			OP_PAGE_WR: begin
				// ignored outside 128K and while control bit 5 (BIT_RAM_HI) is set
				if (is_128k && !ctrl_q[BIT_RAM_HI]) begin
					ctrl_n = in_ch.item.data_byte;
				end
			end
			OP_BIT_WR: begin
				// set or clear one control bit, selected by data bits 3:1
				if (mode_eff == MODE_SHADOW && !ctrl_q[BIT_LOCK_SH]) begin
					ctrl_n[in_ch.item.data_byte[3:1]] = in_ch.item.data_byte[0];
				end
			end
			OP_TRAP_ENTER: begin
				if (!(mode_eff == MODE_48K || mode_eff == MODE_128K) &&
				    !(mode_eff == MODE_SHADOW && ctrl_q[BIT_ROM_SEL])) begin
					disk_n = 1'b1;
				end
			end
			OP_TRAP_EXIT: begin
				disk_n = 1'b0;
			end
			OP_FREEZE_ON: begin
				if (frz_pres_q) begin
					frz_n = 1'b1;
				end
			end
			OP_FREEZE_OFF: begin
				frz_n = 1'b0;
			end
			OP_SPEECH_TGL: begin
				if (spc_pres_q && (mode_eff == MODE_48K || mode_eff == MODE_48K_IF1)) begin
					spc_n = !spc_act_q;
				end
			end
			OP_SPEECH_OFF: begin
				spc_n = 1'b0;
			end
			default: begin
				spc_n = spc_act_q;
			end
		endcase
	end

	// ---- window map from the updated state ----
	always_comb begin
		res.window1_page = PAGE_RAM8;
		res.window2_page = PAGE_RAM4;
		res.window3_page = PAGE_RAM5;
		res.control_byte = ctrl_n;
		res.shadow_video = is_128k && ctrl_n[BIT_VIDEO];

		if (is_128k) begin
			res.window2_page = PAGE_RAM5;
			res.window3_page = PAGE_BANK0 + {1'b0, ctrl_n[2:0]};
		end else if (mode_eff == MODE_SHADOW && ctrl_n[BIT_RAM_HI]) begin
			res.window2_page = PAGE_RAM6;
			res.window3_page = PAGE_RAM7;
		end

		unique case (mode_eff)
			MODE_48K_IF1, MODE_48K_DISK: begin
				if (spc_n)       res.window0_page = PAGE_SPEECH;
				else if (frz_n)  res.window0_page = PAGE_FREEZE;
				else if (disk_n) res.window0_page = PAGE_DISK;
				else             res.window0_page = PAGE_ROM0;
			end
			MODE_128K: begin
				if (frz_n)                   res.window0_page = PAGE_FREEZE;
				else if (ctrl_n[BIT_ROM_SEL]) res.window0_page = PAGE_ROM2;
				else                         res.window0_page = PAGE_ROM0;
			end
			MODE_128K_IF1, MODE_128K_DSK: begin
				if (frz_n)                   res.window0_page = PAGE_FREEZE;
				else if (disk_n)             res.window0_page = PAGE_DISK;
				else if (ctrl_n[BIT_ROM_SEL]) res.window0_page = PAGE_ROM2;
				else                         res.window0_page = PAGE_ROM0;
			end
			MODE_SHADOW: begin
				if (disk_n)                 res.window0_page = PAGE_DISK;
				else if (ctrl_n[BIT_ROM_LO]) res.window0_page = PAGE_ROM0;
				else if (ctrl_n[BIT_VIDEO])  res.window0_page = PAGE_ROM3;
				else                        res.window0_page = PAGE_ROM2;
			end
			default: begin
				// plain 48K
				if (spc_n)      res.window0_page = PAGE_SPEECH;
				else if (frz_n) res.window0_page = PAGE_FREEZE;
				else            res.window0_page = PAGE_ROM0;
			end
		endcase
	end

	// ---- configuration and mapper state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_48K;
			frz_pres_q <= 1'b0;
			spc_pres_q <= 1'b0;
			ctrl_q     <= '0;
			disk_act_q <= 1'b0;
			frz_act_q  <= 1'b0;
			spc_act_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				ctrl_q     <= ctrl_n;
				disk_act_q <= disk_n;
			end
			// hardware removed: drop the overlay too
			if (cfg_we && cfg_index == CFG_FREEZE_PRES && !cfg_data[0]) begin
				frz_act_q <= 1'b0;
			end else if (in_fire) begin
				frz_act_q <= frz_n;
			end
			if (cfg_we && cfg_index == CFG_SPEECH_PRES && !cfg_data[0]) begin
				spc_act_q <= 1'b0;
			end else if (in_fire) begin
				spc_act_q <= spc_n;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MACHINE_MODE: begin
						mode_q <= cfg_data;
					end
					CFG_FREEZE_PRES: begin
						frz_pres_q <= cfg_data[0];
					end
					CFG_SPEECH_PRES: begin
						spc_pres_q <= cfg_data[0];
					end
					default: begin
						mode_q <= mode_q;
					end
				endcase
			end
		end
	end

	// ---- result buffer: head register plus skid entry ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!head_valid_q || out_fire) begin
				// head free next cycle: refill from skid first, else from new
				if (skid_valid_q) begin
					head_valid_q <= 1'b1;
					skid_valid_q <= in_fire;
				end else begin
					head_valid_q <= in_fire;
				end
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!head_valid_q || out_fire) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (in_fire) skid_q <= res;
			end else if (in_fire) begin
				head_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid = head_valid_q;
	assign out_ch.item  = head_q;

	// ---- assertions ----
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid entry held while head empty");

	a_page_wr_48k_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.item.operation == OP_PAGE_WR && !is_128k) |=>
		ctrl_q == $past(ctrl_q))
		else $error("paging write changed control byte outside 128K");

	a_trap_exit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.item.operation == OP_TRAP_EXIT) |=> !disk_act_q)
		else $error("disk overlay still active after trap exit");

	a_freeze_needs_hw: assert property (@(posedge clk) disable iff (!arst_n)
		frz_act_q |-> frz_pres_q)
		else $error("freeze overlay active without hardware");

endmodule
`default_nettype wire
